// ===== sv/wpe_pkg.sv =====
// shared types and constants of the wca pair energy delta block
package wpe_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int POS_W      = 32;
	localparam int DIAM_W     = 24;
	localparam int BOX_W      = 31;
	localparam int IDX_W      = 20;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int SUM_W      = 64;
	localparam int MUL_W      = 64;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int QUOT_W     = 32;
	localparam int REM_W      = 50;
	localparam int D2_W       = 2 * DIAM_W;
	localparam int IN_DATA_W  = 88;

	localparam logic [CFG_IDX_W-1:0] REG_OLD_POS_X     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OLD_POS_Y     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_POS_X     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_POS_Y     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_DIAMETER = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MOVING_INDEX  = 4'd7;

	// cube root of two in q30, applied to d^2 for the cutoff
	localparam logic [30:0] CBRT2_Q30   = 31'd1352829926;
	localparam int          CBRT2_SHIFT = 30;

	localparam logic [SUM_W-1:0] TERM_CAP = 64'h4000_0000_0000_0000;
	localparam logic [SUM_W-1:0] SUM_MAX  = 64'h7fff_ffff_ffff_ffff;
	localparam logic [SUM_W-1:0] SUM_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [POS_W-1:0] MAG_CLAMP = 32'h8000_0000;

	localparam logic [DIAM_W-1:0] DIAM_RESET = 24'd65536;
	localparam logic [BOX_W-1:0]  BOX_RESET  = 31'd65536;

	typedef struct packed {
		logic signed [POS_W-1:0] old_x;
		logic signed [POS_W-1:0] old_y;
		logic signed [POS_W-1:0] new_x;
		logic signed [POS_W-1:0] new_y;
		logic [DIAM_W-1:0]       diam;
		logic [BOX_W-1:0]        box_w;
		logic [BOX_W-1:0]        box_h;
		logic [IDX_W-1:0]        moving;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [REM_W-1:0]  rem_init;
		logic [QUOT_W-1:0] dividend;
		logic [REM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic [REM_W-1:0]  rem;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic [SUM_W-1:0] delta;
		logic             sat;
	} res_t;

endpackage

// ===== sv/wpe_div.sv =====
// shared restoring divider, one quotient bit per cycle
module wpe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wpe_pkg::div_req_t req,
	output wpe_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(wpe_pkg::QUOT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wpe_pkg::QUOT_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [wpe_pkg::REM_W-1:0]  rem_q;
	logic [wpe_pkg::REM_W-1:0]  div_q;
	logic [wpe_pkg::QUOT_W-1:0] lo_q;
	logic [wpe_pkg::QUOT_W-1:0] quot_q;
	logic [wpe_pkg::REM_W-1:0]  trial;
	logic [wpe_pkg::REM_W:0]    diff;

	// remainder stays below the divisor, so its top bit is free for the shift
	assign trial = {rem_q[wpe_pkg::REM_W-2:0], lo_q[wpe_pkg::QUOT_W-1]};
	assign diff  = {1'b0, trial} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			lo_q   <= req.dividend;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			lo_q <= {lo_q[wpe_pkg::QUOT_W-2:0], 1'b0};
			if (!diff[wpe_pkg::REM_W]) begin
				rem_q  <= diff[wpe_pkg::REM_W-1:0];
				quot_q <= {quot_q[wpe_pkg::QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[wpe_pkg::QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== sv/wpe_mul.sv =====
// shared 64x64 multiplier built from four 32x32 partial products
module wpe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  wpe_pkg::mul_req_t req,
	output wpe_pkg::mul_rsp_t rsp
);

	localparam int HALF = wpe_pkg::MUL_W / 2;

	logic                       busy_q;
	logic                       pv_s1;
	logic                       plast_s1;
	logic                       done_q;
	logic [1:0]                 cnt_q;
	logic [1:0]                 sh_s1;
	logic [wpe_pkg::MUL_W-1:0]  a_q;
	logic [wpe_pkg::MUL_W-1:0]  b_q;
	logic [wpe_pkg::MUL_W-1:0]  p_s1;
	logic [wpe_pkg::PROD_W-1:0] acc_q;
	logic [HALF-1:0]            op_a;
	logic [HALF-1:0]            op_b;
	logic [1:0]                 sh;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = a_q[HALF-1:0];
				op_b = b_q[HALF-1:0];
				sh   = 2'd0;
			end
			2'd1: begin
				op_a = a_q[HALF-1:0];
				op_b = b_q[wpe_pkg::MUL_W-1:HALF];
				sh   = 2'd1;
			end
			2'd2: begin
				op_a = a_q[wpe_pkg::MUL_W-1:HALF];
				op_b = b_q[HALF-1:0];
				sh   = 2'd1;
			end
			default: begin
				op_a = a_q[wpe_pkg::MUL_W-1:HALF];
				op_b = b_q[wpe_pkg::MUL_W-1:HALF];
				sh   = 2'd2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pv_s1    <= 1'b0;
			plast_s1 <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			pv_s1    <= busy_q;
			plast_s1 <= busy_q && (cnt_q == 2'd3);
			done_q   <= pv_s1 && plast_s1;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= op_a * op_b;
		sh_s1 <= sh;
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + (wpe_pkg::PROD_W'(p_s1) << (32'(sh_s1) * HALF));
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// ===== sv/wpe_seq.sv =====
// per-neighbour sequencer: minimum image, r^2, cutoff, wca term and running sum
module wpe_seq #(
	parameter int FRAC_BITS = wpe_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wpe_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_kind,
	input  logic [wpe_pkg::POS_W-1:0]  in_x,
	input  logic [wpe_pkg::POS_W-1:0]  in_y,
	input  logic [wpe_pkg::IDX_W-1:0]  in_index,
	input  logic                       in_last,
	output logic                       res_valid,
	input  logic                       res_ready,
	output wpe_pkg::res_t              res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_XMOD = 4'd1;
	localparam logic [3:0] S_YMOD = 4'd2;
	localparam logic [3:0] S_RXX  = 4'd3;
	localparam logic [3:0] S_RYY  = 4'd4;
	localparam logic [3:0] S_D2   = 4'd5;
	localparam logic [3:0] S_CUT  = 4'd6;
	localparam logic [3:0] S_RDIV = 4'd7;
	localparam logic [3:0] S_S2   = 4'd8;
	localparam logic [3:0] S_S3   = 4'd9;
	localparam logic [3:0] S_S6   = 4'd10;
	localparam logic [3:0] S_TERM = 4'd11;
	localparam logic [3:0] S_SUM  = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	localparam int NUM_W = 80;
	localparam logic [wpe_pkg::SUM_W-1:0] ONE_Q = 64'(1) << FRAC_BITS;
	localparam logic [wpe_pkg::SUM_W-1:0] TERM_LIMIT = (wpe_pkg::TERM_CAP - ONE_Q) >> 2;

	logic [3:0]                       state_q;
	logic                             go_q;
	logic                             kind_q;
	logic                             last_q;
	logic [wpe_pkg::POS_W-1:0]        nx_q;
	logic [wpe_pkg::POS_W-1:0]        ny_q;
	logic [wpe_pkg::POS_W-1:0]        mx_q;
	logic [wpe_pkg::POS_W-1:0]        my_q;
	logic [wpe_pkg::SUM_W-1:0]        r2_q;
	logic [wpe_pkg::D2_W-1:0]         d2_q;
	logic [wpe_pkg::QUOT_W-1:0]       s_q;
	logic [wpe_pkg::SUM_W-1:0]        s2_q;
	logic [wpe_pkg::SUM_W-1:0]        s3_q;
	logic [wpe_pkg::SUM_W-1:0]        s6_q;
	logic [wpe_pkg::SUM_W-1:0]        term_q;
	logic                             tsat_q;
	logic [wpe_pkg::SUM_W-1:0]        sum_q;
	logic                             ssat_q;

	wpe_pkg::div_req_t div_req;
	wpe_pkg::div_rsp_t div_rsp;
	wpe_pkg::mul_req_t mul_req;
	wpe_pkg::mul_rsp_t mul_rsp;

	logic [wpe_pkg::POS_W-1:0]   cx;
	logic [wpe_pkg::POS_W-1:0]   cy;
	logic [wpe_pkg::POS_W:0]     dx;
	logic [wpe_pkg::POS_W:0]     dy;
	logic                        on_y;
	logic [wpe_pkg::POS_W:0]     cur_dx;
	logic [wpe_pkg::POS_W:0]     neg_dx;
	logic [wpe_pkg::BOX_W-1:0]   cur_box;
	logic                        dx_neg;
	logic [wpe_pkg::POS_W-1:0]   dx_abs;
	logic [wpe_pkg::POS_W-1:0]   dx_clamp;
	logic [wpe_pkg::BOX_W-1:0]   rem_box;
	logic [wpe_pkg::BOX_W-1:0]   m_wrap;
	logic [wpe_pkg::BOX_W-1:0]   m_fold;
	logic [wpe_pkg::POS_W-1:0]   mag_fold;
	logic [NUM_W-1:0]            num;
	logic                        ratio_sat;
	logic [wpe_pkg::SUM_W-1:0]   cut_val;
	logic [wpe_pkg::SUM_W:0]     pw;
	logic                        mul_state;
	logic                        mul_fire;
	logic [wpe_pkg::SUM_W-1:0]   diff;
	logic [wpe_pkg::SUM_W-1:0]   addend;
	logic [wpe_pkg::SUM_W:0]     sum_wide;
	logic                        ovf;
	logic [wpe_pkg::SUM_W-1:0]   sum_next;

	// floor(p / 2^F) with saturation above 2^62, flag in the top bit
	function automatic logic [wpe_pkg::SUM_W:0] pow_sat(input logic [wpe_pkg::PROD_W-1:0] p);
		logic [wpe_pkg::PROD_W-1:0] shv;
		logic                       over;
		shv  = p >> FRAC_BITS;
		over = (|shv[wpe_pkg::PROD_W-1:63]) || (shv[62] && (|shv[61:0]));
		return over ? {1'b1, wpe_pkg::TERM_CAP} : {1'b0, shv[wpe_pkg::SUM_W-1:0]};
	endfunction

	// separation of the current axis
	assign cx      = kind_q ? cfg.new_x : cfg.old_x;
	assign cy      = kind_q ? cfg.new_y : cfg.old_y;
	assign dx      = {nx_q[wpe_pkg::POS_W-1], nx_q} - {cx[wpe_pkg::POS_W-1], cx};
	assign dy      = {ny_q[wpe_pkg::POS_W-1], ny_q} - {cy[wpe_pkg::POS_W-1], cy};
	assign on_y    = (state_q == S_YMOD);
	assign cur_dx  = on_y ? dy : dx;
	assign cur_box = on_y ? cfg.box_h : cfg.box_w;
	assign dx_neg  = cur_dx[wpe_pkg::POS_W];
	assign neg_dx  = -cur_dx;
	assign dx_abs  = dx_neg ? neg_dx[wpe_pkg::POS_W-1:0] : cur_dx[wpe_pkg::POS_W-1:0];
	assign dx_clamp = (dx_abs > wpe_pkg::MAG_CLAMP) ? wpe_pkg::MAG_CLAMP : dx_abs;

	// turn |dx| mod L into the folded magnitude in [0, L/2]
	assign rem_box  = div_rsp.rem[wpe_pkg::BOX_W-1:0];
	assign m_wrap   = (dx_neg && (rem_box != '0)) ? (cur_box - rem_box) : rem_box;
	assign m_fold   = ({m_wrap, 1'b0} > {1'b0, cur_box}) ? (cur_box - m_wrap) : m_wrap;
	assign mag_fold = wpe_pkg::POS_W'(m_fold);

	assign num       = NUM_W'(d2_q) << FRAC_BITS;
	assign ratio_sat = (r2_q == '0) ||
		(wpe_pkg::SUM_W'(num[NUM_W-1:wpe_pkg::QUOT_W]) >= r2_q);
	assign cut_val   = wpe_pkg::SUM_W'(mul_rsp.prod >> wpe_pkg::CBRT2_SHIFT);
	assign pw        = pow_sat(mul_rsp.prod);

	assign mul_state = (state_q == S_RXX) || (state_q == S_RYY) || (state_q == S_D2) ||
		(state_q == S_CUT) || (state_q == S_S2) || (state_q == S_S3) ||
		(state_q == S_S6);
	assign mul_fire = !go_q && mul_rsp.done;

	always_comb begin
		div_req.start = go_q && (((state_q == S_XMOD || state_q == S_YMOD) && cur_box != '0) ||
			(state_q == S_RDIV && !ratio_sat));
		if (state_q == S_RDIV) begin
			div_req.rem_init = wpe_pkg::REM_W'(num[NUM_W-1:wpe_pkg::QUOT_W]);
			div_req.dividend = num[wpe_pkg::QUOT_W-1:0];
			div_req.divisor  = r2_q[wpe_pkg::REM_W-1:0];
		end else begin
			div_req.rem_init = '0;
			div_req.dividend = dx_abs;
			div_req.divisor  = wpe_pkg::REM_W'(cur_box);
		end
	end

	always_comb begin
		mul_req.start = go_q && mul_state;
		case (state_q)
			S_RXX: begin
				mul_req.a = wpe_pkg::MUL_W'(mx_q);
				mul_req.b = wpe_pkg::MUL_W'(mx_q);
			end
			S_RYY: begin
				mul_req.a = wpe_pkg::MUL_W'(my_q);
				mul_req.b = wpe_pkg::MUL_W'(my_q);
			end
			S_D2: begin
				mul_req.a = wpe_pkg::MUL_W'(cfg.diam);
				mul_req.b = wpe_pkg::MUL_W'(cfg.diam);
			end
			S_CUT: begin
				mul_req.a = wpe_pkg::MUL_W'(d2_q);
				mul_req.b = wpe_pkg::MUL_W'(wpe_pkg::CBRT2_Q30);
			end
			S_S2: begin
				mul_req.a = wpe_pkg::MUL_W'(s_q);
				mul_req.b = wpe_pkg::MUL_W'(s_q);
			end
			S_S3: begin
				mul_req.a = s2_q;
				mul_req.b = wpe_pkg::MUL_W'(s_q);
			end
			S_S6: begin
				mul_req.a = s3_q;
				mul_req.b = s3_q;
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	// term and saturating accumulate
	assign diff     = s6_q - s3_q;
	assign addend   = kind_q ? term_q : -term_q;
	assign sum_wide = {sum_q[wpe_pkg::SUM_W-1], sum_q} + {addend[wpe_pkg::SUM_W-1], addend};
	assign ovf      = sum_wide[wpe_pkg::SUM_W] != sum_wide[wpe_pkg::SUM_W-1];
	assign sum_next = ovf ? (sum_wide[wpe_pkg::SUM_W] ? wpe_pkg::SUM_MIN : wpe_pkg::SUM_MAX) :
		sum_wide[wpe_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
			kind_q  <= 1'b0;
			last_q  <= 1'b0;
			nx_q    <= '0;
			ny_q    <= '0;
			mx_q    <= '0;
			my_q    <= '0;
			r2_q    <= '0;
			d2_q    <= '0;
			s_q     <= '0;
			s2_q    <= '0;
			s3_q    <= '0;
			s6_q    <= '0;
			term_q  <= '0;
			tsat_q  <= 1'b0;
			sum_q   <= '0;
			ssat_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= in_kind;
						last_q <= in_last;
						nx_q   <= in_x;
						ny_q   <= in_y;
						tsat_q <= 1'b0;
						go_q   <= 1'b1;
						// the moved particle itself adds nothing
						state_q <= (in_index == cfg.moving) ? S_FIN : S_XMOD;
					end
				end
				S_XMOD, S_YMOD: begin
					if (go_q && cur_box == '0) begin
						// unwrapped axis
						if (on_y) begin
							my_q <= dx_clamp;
						end else begin
							mx_q <= dx_clamp;
						end
						state_q <= on_y ? S_RXX : S_YMOD;
					end else if (go_q) begin
						go_q <= 1'b0;
					end else if (div_rsp.done) begin
						if (on_y) begin
							my_q <= mag_fold;
						end else begin
							mx_q <= mag_fold;
						end
						go_q    <= 1'b1;
						state_q <= on_y ? S_RXX : S_YMOD;
					end
				end
				S_RXX: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						r2_q    <= mul_rsp.prod[wpe_pkg::SUM_W-1:0];
						go_q    <= 1'b1;
						state_q <= S_RYY;
					end
				end
				S_RYY: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						r2_q    <= r2_q + mul_rsp.prod[wpe_pkg::SUM_W-1:0];
						go_q    <= 1'b1;
						state_q <= S_D2;
					end
				end
				S_D2: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						d2_q    <= mul_rsp.prod[wpe_pkg::D2_W-1:0];
						go_q    <= 1'b1;
						state_q <= S_CUT;
					end
				end
				S_CUT: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						go_q    <= 1'b1;
						state_q <= (r2_q <= cut_val) ? S_RDIV : S_FIN;
					end
				end
				S_RDIV: begin
					if (go_q && ratio_sat) begin
						// zero distance or quotient beyond 32 bits
						s_q     <= '1;
						tsat_q  <= 1'b1;
						state_q <= S_TERM;
					end else if (go_q) begin
						go_q <= 1'b0;
					end else if (div_rsp.done) begin
						s_q     <= div_rsp.quot;
						go_q    <= 1'b1;
						state_q <= S_S2;
					end
				end
				S_S2: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						s2_q    <= pw[wpe_pkg::SUM_W-1:0];
						go_q    <= 1'b1;
						tsat_q  <= pw[wpe_pkg::SUM_W];
						state_q <= pw[wpe_pkg::SUM_W] ? S_TERM : S_S3;
					end
				end
				S_S3: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						s3_q    <= pw[wpe_pkg::SUM_W-1:0];
						go_q    <= 1'b1;
						tsat_q  <= pw[wpe_pkg::SUM_W];
						state_q <= pw[wpe_pkg::SUM_W] ? S_TERM : S_S6;
					end
				end
				S_S6: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (mul_fire) begin
						s6_q    <= pw[wpe_pkg::SUM_W-1:0];
						tsat_q  <= pw[wpe_pkg::SUM_W];
						state_q <= S_TERM;
					end
				end
				S_TERM: begin
					if (tsat_q) begin
						term_q <= wpe_pkg::TERM_CAP;
					end else if ($signed(diff) > $signed(TERM_LIMIT)) begin
						term_q <= wpe_pkg::TERM_CAP;
						tsat_q <= 1'b1;
					end else begin
						term_q <= (diff << 2) + ONE_Q;
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q   <= sum_next;
					ssat_q  <= ssat_q | tsat_q | ovf;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (res_ready) begin
						sum_q   <= '0;
						ssat_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN) && last_q;
	assign res.delta = sum_q;
	assign res.sat   = ssat_q;

	wpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule

// ===== sv/wca_pair_energy_delta.sv =====
// top level of the wca pair energy delta block: config registers, streams, output register
//
// Streams the neighbours of one trial move and returns the wca energy change.
// Setup: write the old and trial positions, diameter, box lengths and moved
// particle index on the cfg port (cfg_index selects the register, cfg_ready is
// always high); do this only while no neighbour is in flight.
// Input: one neighbour per s_axis transaction; tuser is the side (0 old, 1 trial),
// tlast marks the final neighbour of the move.
// Output: one m_axis transaction after each tlast item, tdata is the signed
// energy change, tuser flags that a term or the sum saturated. The sum clears
// once that transaction is handed to the output register.
// Timing: one neighbour at a time; s_axis_tready is low while it is worked on.
// The moved particle itself skips all work and a neighbour beyond the cutoff
// stops at the cutoff test. Each wrapped axis costs a run of the bit-serial
// divider, the d^2/r^2 ratio another, and each of the seven products a pass
// through the 32x32 partial products of the multiplier.
// The output register holds a result until taken; a stalled m_axis only holds
// the block back when the next tlast item finishes.
// Reset clears the running sum and the flag and returns the config registers to their defaults.
module wca_pair_energy_delta #(
	parameter int FRAC_BITS = wpe_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wpe_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// neighbour_x, neighbour_y, neighbour_index, zero pad
	input  logic [wpe_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                              s_axis_tlast,
	// kind
	input  logic [0:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// energy_delta
	output logic [wpe_pkg::SUM_W-1:0]         m_axis_tdata,
	// saturated
	output logic [0:0]                        m_axis_tuser
);

	wpe_pkg::cfg_t cfg_q;
	wpe_pkg::res_t res;
	logic          res_valid;
	logic          res_ready;
	logic          m_valid_q;
	logic [wpe_pkg::SUM_W-1:0] m_data_q;
	logic          m_sat_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.old_x  <= '0;
			cfg_q.old_y  <= '0;
			cfg_q.new_x  <= '0;
			cfg_q.new_y  <= '0;
			cfg_q.diam   <= wpe_pkg::DIAM_RESET;
			cfg_q.box_w  <= wpe_pkg::BOX_RESET;
			cfg_q.box_h  <= wpe_pkg::BOX_RESET;
			cfg_q.moving <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wpe_pkg::REG_OLD_POS_X:     cfg_q.old_x  <= cfg_data;
				wpe_pkg::REG_OLD_POS_Y:     cfg_q.old_y  <= cfg_data;
				wpe_pkg::REG_NEW_POS_X:     cfg_q.new_x  <= cfg_data;
				wpe_pkg::REG_NEW_POS_Y:     cfg_q.new_y  <= cfg_data;
				wpe_pkg::REG_CORE_DIAMETER: cfg_q.diam   <= cfg_data[wpe_pkg::DIAM_W-1:0];
				wpe_pkg::REG_BOX_WIDTH:     cfg_q.box_w  <= cfg_data[wpe_pkg::BOX_W-1:0];
				wpe_pkg::REG_BOX_HEIGHT:    cfg_q.box_h  <= cfg_data[wpe_pkg::BOX_W-1:0];
				wpe_pkg::REG_MOVING_INDEX:  cfg_q.moving <= cfg_data[wpe_pkg::IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wpe_seq #(
		.FRAC_BITS (FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser[0]),
		.in_x      (s_axis_tdata[31:0]),
		.in_y      (s_axis_tdata[63:32]),
		.in_index  (s_axis_tdata[83:64]),
		.in_last   (s_axis_tlast),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register frees the core as soon as the result is parked
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_data_q <= res.delta;
			m_sat_q  <= res.sat;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_sat_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a neighbour is in flight");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !res_valid)
		else $error("result pending while the core reports idle");

	a_handoff_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_axis_tvalid && m_axis_tdata == $past(res.delta))
		else $error("result lost between core and output register");

endmodule

// ===== sim/wca_pair_energy_delta_checker.sv =====
// scoreboard of the wca pair energy delta block: follows register writes, predicts and compares each energy change
module wca_pair_energy_delta_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [wpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	// neighbour_x, neighbour_y, neighbour_index, zero pad
	input  logic [wpe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tlast,
	// kind
	input  logic [0:0]                     s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// energy_delta
	input  logic [wpe_pkg::SUM_W-1:0]      m_axis_tdata,
	// saturated
	input  logic [0:0]                     m_axis_tuser,
	output int                             mismatches,
	output int                             pending,
	output int                             results_seen
);
	import wpe_pkg::*;

	localparam int          F          = FRAC_BITS_DEF;
	localparam logic [63:0] ONE_Q      = 64'd1 << F;
	localparam int          SHOW_FIRST = 10;

	cfg_t               regs;
	logic signed [63:0] run_sum;
	bit                 run_sat;
	res_t               delta_q[$];
	int                 fails;
	int                 n_results;

	// minimum-image separation along one axis, clamped to 2^31
	function automatic logic [63:0] axis_mag(logic signed [31:0] a, logic signed [31:0] b,
			logic [30:0] len);
		logic signed [63:0] d;
		logic signed [63:0] l;
		logic signed [63:0] m;
		logic [63:0]        mag;
		d = a - b;
		l = {33'd0, len};
		if (len != 0) begin
			m = d % l;
			if (m < 0)
				m = m + l;
			if (m * 2 > l)
				m = m - l;
			d = m;
		end
		mag = (d < 0) ? -d : d;
		if (mag > 64'h8000_0000)
			mag = 64'h8000_0000;
		return mag;
	endfunction

	function automatic logic [63:0] cutoff_of(logic [63:0] d2);
		logic [127:0] p;
		p = {64'd0, d2} * {97'd0, CBRT2_Q30};
		p = p >> CBRT2_SHIFT;
		return p[63:0];
	endfunction

	// floor(a*b / 2^F), capped
	function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b, inout bit sat);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> F;
		if (p > {64'd0, TERM_CAP}) begin
			sat = 1'b1;
			return TERM_CAP;
		end
		return p[63:0];
	endfunction

	// floor(d2 * 2^F / r2), capped at 32 bits
	function automatic logic [63:0] ratio_q(logic [63:0] d2, logic [63:0] r2, inout bit sat);
		logic [127:0] q;
		if (r2 == 0) begin
			sat = 1'b1;
			return 64'hFFFF_FFFF;
		end
		q = ({64'd0, d2} << F) / {64'd0, r2};
		if (q >= 128'h1_0000_0000) begin
			sat = 1'b1;
			return 64'hFFFF_FFFF;
		end
		return q[63:0];
	endfunction

	function automatic void wca_term(input logic [63:0] r2, input logic [63:0] d2,
			output logic signed [63:0] term, output bit sat);
		logic [63:0]        s;
		logic [63:0]        s2;
		logic [63:0]        s3;
		logic [63:0]        s6;
		logic signed [63:0] diff;
		logic [63:0]        lim;
		sat = 1'b0;
		s  = ratio_q(d2, r2, sat);
		s2 = mul_q(s, s, sat);
		s3 = mul_q(s2, s, sat);
		s6 = mul_q(s3, s3, sat);
		lim = (TERM_CAP - ONE_Q) >> 2;
		if (sat) begin
			term = TERM_CAP;
		end else begin
			diff = $signed(s6) - $signed(s3);
			if (diff > $signed(lim)) begin
				term = TERM_CAP;
				sat = 1'b1;
			end else begin
				term = diff * 4 + $signed(ONE_Q);
			end
		end
	endfunction

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b,
			inout bit sat);
		logic signed [63:0] t;
		t = a + b;
		if (a[63] == b[63] && t[63] != a[63]) begin
			sat = 1'b1;
			return a[63] ? $signed(SUM_MIN) : $signed(SUM_MAX);
		end
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [IDX_W-1:0]   nidx;
		bit                 trial;
		logic [63:0]        mx;
		logic [63:0]        my;
		logic [63:0]        r2;
		logic [63:0]        d2;
		logic signed [63:0] term;
		bit                 tsat;
		res_t               got;
		res_t               want;
		if (!arst_n) begin
			regs       = '0;
			regs.diam  = DIAM_RESET;
			regs.box_w = BOX_RESET;
			regs.box_h = BOX_RESET;
			run_sum    = '0;
			run_sat    = 1'b0;
			delta_q.delete();
			fails      = 0;
			n_results  = 0;
			mismatches   <= 0;
			pending      <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OLD_POS_X:     regs.old_x  = cfg_data;
					REG_OLD_POS_Y:     regs.old_y  = cfg_data;
					REG_NEW_POS_X:     regs.new_x  = cfg_data;
					REG_NEW_POS_Y:     regs.new_y  = cfg_data;
					REG_CORE_DIAMETER: regs.diam   = cfg_data[DIAM_W-1:0];
					REG_BOX_WIDTH:     regs.box_w  = cfg_data[BOX_W-1:0];
					REG_BOX_HEIGHT:    regs.box_h  = cfg_data[BOX_W-1:0];
					REG_MOVING_INDEX:  regs.moving = cfg_data[IDX_W-1:0];
					default: ;
				endcase
			end

			// compare before queuing, so a result can never meet its own prediction early
			if (m_axis_tvalid && m_axis_tready) begin
				got.delta = m_axis_tdata;
				got.sat   = m_axis_tuser[0];
				if (delta_q.size() == 0) begin
					fails++;
					if (fails <= SHOW_FIRST)
						$display("energy result %0d with nothing pending: delta %0d sat %0b",
							n_results, $signed(got.delta), got.sat);
				end else begin
					want = delta_q.pop_front();
					if (got.delta !== want.delta || got.sat !== want.sat) begin
						fails++;
						if (fails <= SHOW_FIRST)
							$display("energy result %0d: expected delta %0d sat %0b, got delta %0d sat %0b",
								n_results, $signed(want.delta), want.sat,
								$signed(got.delta), got.sat);
					end
				end
				n_results++;
			end

			if (s_axis_tvalid && s_axis_tready) begin
				nx    = s_axis_tdata[31:0];
				ny    = s_axis_tdata[63:32];
				nidx  = s_axis_tdata[64 +: IDX_W];
				trial = s_axis_tuser[0];
				if (nidx != regs.moving) begin
					mx = axis_mag(nx, trial ? regs.new_x : regs.old_x, regs.box_w);
					my = axis_mag(ny, trial ? regs.new_y : regs.old_y, regs.box_h);
					r2 = mx * mx + my * my;
					d2 = 64'(regs.diam) * 64'(regs.diam);
					if (r2 <= cutoff_of(d2)) begin
						wca_term(r2, d2, term, tsat);
						if (tsat)
							run_sat = 1'b1;
						run_sum = add_sat(run_sum, trial ? term : -term, run_sat);
					end
				end
				if (s_axis_tlast) begin
					want.delta = run_sum;
					want.sat   = run_sat;
					delta_q.push_back(want);
					run_sum = '0;
					run_sat = 1'b0;
				end
			end

			mismatches   <= fails;
			results_seen <= n_results;
			pending      <= delta_q.size();
		end
	end

endmodule

// ===== sim/wca_pair_energy_delta_tb.sv =====
// testbench top of the wca pair energy delta block: clock, reset, stimulus and verdict
module wca_pair_energy_delta_tb;
	import wpe_pkg::*;

	// limit well over the slowest item plus gaps and stalls, times the 480-plus neighbours sent
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE       = 400;
	localparam int RANDOM_ITEMS = 480;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

	localparam int SET_WILD  = 0;
	localparam int SET_OPEN  = 1;
	localparam int SET_BOXED = 2;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic [0:0]            s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [SUM_W-1:0]      m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	int mismatches;
	int pending;
	int results_seen;

	int   cycles          = 0;
	int   neighbours_sent = 0;
	int   moves_sent      = 0;
	int   settings_used   = 0;
	cfg_t now_cfg;

	always #10 clk = ~clk;

	wca_pair_energy_delta u_dut (.*);

	wca_pair_energy_delta_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int spread(int half);
		int v;
		v = $urandom_range(0, 2 * half);
		return v - half;
	endfunction

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// leaves cfg_valid high so back-to-back writes need no toggle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(cfg_t c);
		write_reg(REG_OLD_POS_X, c.old_x);
		write_reg(REG_OLD_POS_Y, c.old_y);
		write_reg(REG_NEW_POS_X, c.new_x);
		write_reg(REG_NEW_POS_Y, c.new_y);
		// junk in the bits above each narrow register
		write_reg(REG_CORE_DIAMETER, {8'($urandom), c.diam});
		write_reg(REG_BOX_WIDTH, {1'($urandom), c.box_w});
		write_reg(REG_BOX_HEIGHT, {1'($urandom), c.box_h});
		write_reg(REG_MOVING_INDEX, {12'($urandom), c.moving});
		write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
		cfg_valid <= 1'b0;
		now_cfg = c;
		settings_used++;
	endtask

	task automatic send_neighbour(bit kind, logic [31:0] x, logic [31:0] y,
			logic [IDX_W-1:0] idx, bit last, int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, idx, y, x};
		s_axis_tuser  <= kind;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		neighbours_sent++;
		if (last)
			moves_sent++;
	endtask

	// sender holds off until every result is back, then lets the block drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic cfg_t random_setting(int style);
		cfg_t c;
		int   d;
		int   bw;
		int   bh;
		int   ox;
		int   oy;
		c.moving = $urandom;
		if (style == SET_WILD) begin
			c.old_x = $urandom;
			c.old_y = $urandom;
			c.new_x = $urandom;
			c.new_y = $urandom;
			c.diam  = $urandom;
			c.box_w = $urandom;
			c.box_h = $urandom;
			return c;
		end
		d = $urandom_range(16384, 196608);
		c.diam = d;
		if (style == SET_OPEN) begin
			c.box_w = '0;
			c.box_h = '0;
			ox = spread(1 << 20);
			oy = spread(1 << 20);
		end else begin
			bw = d * $urandom_range(3, 20) + $urandom_range(0, d);
			bh = d * $urandom_range(3, 20) + $urandom_range(0, d);
			c.box_w = bw;
			c.box_h = bh;
			ox = $urandom_range(0, bw - 1);
			oy = $urandom_range(0, bh - 1);
		end
		c.old_x = ox;
		c.old_y = oy;
		c.new_x = ox + spread(d / 2);
		c.new_y = oy + spread(d / 2);
		return c;
	endfunction

	// one trial move: count neighbours, the last one carries tlast
	task automatic random_move(int count, bit steady);
		bit               kind;
		int               r;
		int               reach;
		logic [31:0]      cx;
		logic [31:0]      cy;
		logic [31:0]      x;
		logic [31:0]      y;
		logic [IDX_W-1:0] idx;
		reach = int'(now_cfg.diam) * 13 / 10 + 1;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 1);
			cx = kind ? now_cfg.new_x : now_cfg.old_x;
			cy = kind ? now_cfg.new_y : now_cfg.old_y;
			r = $urandom_range(0, 99);
			if (r < 78) begin
				x = cx + spread(reach);
				y = cy + spread(reach);
			end else if (r < 92) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = cx;
				y = cy;
			end
			idx = ($urandom_range(0, 15) == 0) ? now_cfg.moving : IDX_W'($urandom);
			send_neighbour(kind, x, y, idx, i == count - 1, steady ? 0 : sender_gap());
		end
	endtask

	// receiver: mostly short stalls, a few long ones, and now and then a long clear stretch
	initial begin : rx_stall
		int r;
		int run;
		int gap;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			run = (r < 90) ? $urandom_range(1, 20) : $urandom_range(200, 1500);
			m_axis_tready <= 1'b1;
			repeat (run) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 60)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 5);
			else if (r < 97)
				gap = $urandom_range(6, 30);
			else
				gap = $urandom_range(50, 150);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		cfg_t c;
		int   phase;
		int   style;
		int   quota;
		int   n;
		int   cnt;
		int   random_start;
		bit   steady;

		now_cfg       = '0;
		now_cfg.diam  = DIAM_RESET;
		now_cfg.box_w = BOX_RESET;
		now_cfg.box_h = BOX_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// values after reset: centre at origin, unit diameter and box
		send_neighbour(1'b1, 32'h0, 32'h0, now_cfg.moving, 1'b1, 0);
		send_neighbour(1'b1, 32'h0, 32'h0, 20'd1, 1'b1, 0);
		send_neighbour(1'b0, 32'h0, 32'h0, 20'd1, 1'b1, 1);
		send_neighbour(1'b1, 32'h0000_8000, 32'h0, 20'd2, 1'b0, 0);
		send_neighbour(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF, 1'b0, 2);
		send_neighbour(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 20'd5, 1'b1, 0);
		// stacked capped terms run the sum into both rails
		repeat (3) send_neighbour(1'b1, 32'h0, 32'h0, 20'd3, 1'b0, 0);
		send_neighbour(1'b1, 32'h0, 32'h0, now_cfg.moving, 1'b1, 0);
		repeat (3) send_neighbour(1'b0, 32'h0, 32'h0, 20'd3, 1'b0, 0);
		send_neighbour(1'b0, 32'h0, 32'h0, now_cfg.moving, 1'b1, 0);
		settle();

		// extreme positions, largest diameter, no wrapping
		c.old_x  = 32'h8000_0000;
		c.old_y  = 32'h7FFF_FFFF;
		c.new_x  = 32'h7FFF_FFFF;
		c.new_y  = 32'h8000_0000;
		c.diam   = 24'hFF_FFFF;
		c.box_w  = '0;
		c.box_h  = '0;
		c.moving = 20'hFFFFF;
		apply_setting(c);
		send_neighbour(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 20'd1, 1'b0, 0);
		send_neighbour(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0, 1'b0, 0);
		// exactly one diameter away: s is one
		send_neighbour(1'b0, 32'h80FF_FFFF, 32'h7FFF_FFFF, 20'd7, 1'b0, 3);
		send_neighbour(1'b1, 32'h0, 32'h0, 20'hFFFFF, 1'b1, 0);
		settle();

		// zero diameter, widest and narrowest box
		c        = '0;
		c.box_w  = 31'h7FFF_FFFF;
		c.box_h  = 31'd1;
		apply_setting(c);
		send_neighbour(1'b1, 32'h0, 32'h1234_5678, 20'd2, 1'b0, 0);
		send_neighbour(1'b0, 32'h1, 32'h0, 20'd3, 1'b1, 0);

		random_start = neighbours_sent;
		phase = 0;
		while (neighbours_sent - random_start < RANDOM_ITEMS) begin
			if (phase == 0)
				style = SET_WILD;
			else if (phase == 1)
				style = SET_OPEN;
			else if ($urandom_range(0, 9) == 0)
				style = SET_WILD;
			else if ($urandom_range(0, 9) == 0)
				style = SET_OPEN;
			else
				style = SET_BOXED;
			settle();
			apply_setting(random_setting(style));
			steady = ($urandom_range(0, 3) == 0);
			quota = $urandom_range(40, 80);
			n = 0;
			while (n < quota) begin
				cnt = $urandom_range(1, 12);
				random_move(cnt, steady);
				n += cnt;
			end
			phase++;
		end
		settle();

		$display("sent %0d neighbours in %0d trial moves under %0d register settings",
			neighbours_sent, moves_sent, settings_used);
		$display("compared %0d energy results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/wpe_pkg.sv
sv/wpe_div.sv
sv/wpe_mul.sv
sv/wpe_seq.sv
sv/wca_pair_energy_delta.sv
sim/wca_pair_energy_delta_checker.sv
sim/wca_pair_energy_delta_tb.sv
